FILE: rtl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the Brainfuck bytecode execution core.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int TAPE_DEPTH_DEF = 32768;
    localparam int CELL_BITS_DEF  = 32;
    localparam int PC_BITS_DEF    = 16;

    localparam int LEN_BITS  = 16;
    localparam int NPC_BITS  = 16;
    localparam int DIST_BITS = 8;
    localparam int CHAR_BITS = 8;

    localparam int S_DATA_BITS = 24;
    localparam int S_USER_BITS = 3;
    localparam int M_DATA_BITS = 32;

    typedef enum logic [2:0] {
        OP_PTR_INC  = 3'd0,
        OP_PTR_DEC  = 3'd1,
        OP_CELL_INC = 3'd2,
        OP_CELL_DEC = 3'd3,
        OP_OUT      = 3'd4,
        OP_IN       = 3'd5,
        OP_BR_ZERO  = 3'd6,
        OP_BR_NZERO = 3'd7
    } op_t;

    typedef struct packed {
        logic cell_we;
        logic ptr_move;
        logic out_valid;
    } exec_ctrl_t;

endpackage

FILE: rtl/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bbc_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_exec
// Instruction execute logic: next pointer, next cell value and next counter.
// ----------------------------------------------------------------------------
module bbc_exec
    import bbc_pkg::*;
#(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
    parameter int CELL_BITS  = CELL_BITS_DEF,
    parameter int PC_BITS    = PC_BITS_DEF
) (
    input  op_t                           op,
    input  logic [DIST_BITS-1:0]          jdist,
    input  logic [CHAR_BITS-1:0]          cbyte,
    input  logic                          ceof,
    input  logic [CELL_BITS-1:0]          cell_in,
    input  logic [$clog2(TAPE_DEPTH)-1:0] dp,
    input  logic [PC_BITS-1:0]            pc,
    output exec_ctrl_t                    ctrl,
    output logic [CELL_BITS-1:0]          cell_next,
    output logic [$clog2(TAPE_DEPTH)-1:0] dp_next,
    output logic [PC_BITS-1:0]            pc_next
);

    localparam int DP_BITS = $clog2(TAPE_DEPTH);
    localparam logic [DP_BITS-1:0] DP_LAST = DP_BITS'(TAPE_DEPTH - 1);

    logic [PC_BITS-1:0] pc_inc;
    logic [PC_BITS-1:0] dist_ext;
    logic               cell_zero;

    assign pc_inc    = pc + 1'b1;
    assign dist_ext  = PC_BITS'(jdist);
    assign cell_zero = (cell_in == '0);

    always_comb
    begin
        ctrl      = '0;
        cell_next = cell_in;
        dp_next   = dp;
        pc_next   = pc_inc;
        unique case (op)
            OP_PTR_INC:
            begin
                dp_next       = (dp == DP_LAST) ? '0 : dp + 1'b1;
                ctrl.ptr_move = 1'b1;
            end
            OP_PTR_DEC:
            begin
                dp_next       = (dp == '0) ? DP_LAST : dp - 1'b1;
                ctrl.ptr_move = 1'b1;
            end
            OP_CELL_INC:
            begin
                cell_next    = cell_in + 1'b1;
                ctrl.cell_we = 1'b1;
            end
            OP_CELL_DEC:
            begin
                cell_next    = cell_in - 1'b1;
                ctrl.cell_we = 1'b1;
            end
            OP_OUT:
            begin
                ctrl.out_valid = 1'b1;
            end
            OP_IN:
            begin
                cell_next    = ceof ? '1 : CELL_BITS'(cbyte);
                ctrl.cell_we = 1'b1;
            end
            OP_BR_ZERO:
            begin
                pc_next = cell_zero ? pc + dist_ext : pc_inc;
            end
            OP_BR_NZERO:
            begin
                pc_next = cell_zero ? pc_inc : pc - dist_ext;
            end
            default:
            begin
                pc_next = pc_inc;
            end
        endcase
    end

endmodule

FILE: rtl/brainfuck_bytecode_core_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_bytecode_core_unit
// Execution core of a Brainfuck bytecode machine with a 32-bit cell tape.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one fetched instruction per transaction; the m_
//   channel returns one result per instruction: next counter, output
//   character and halt status. Write program_length on cfg_we/cfg_wdata
//   while the core is idle.
//   Throughput is one instruction per cycle while s_tready is high; the
//   result reaches the output register in the cycle after the input
//   transaction. The current cell is held in a register; a pointer move
//   reads the new cell from the tape RAM, whose data arrives in time for
//   the next instruction. After reset the tape RAM is swept to zero, one
//   cell per cycle, over all TAPE_DEPTH cells (32768 by default); s_tready
//   stays low during the sweep. Configuration writes are taken during the
//   sweep. When the receiver stalls, the output register holds its result
//   and s_tready drops until the result is taken. Once halted, every
//   further instruction returns the unchanged counter with halted set.
// ----------------------------------------------------------------------------
module brainfuck_bytecode_core_unit
    import bbc_pkg::*;
#(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
    parameter int CELL_BITS  = CELL_BITS_DEF,
    parameter int PC_BITS    = PC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [LEN_BITS-1:0]    cfg_wdata,    // program_length
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,      // jump_distance, console_byte, console_eof
    input  logic [S_USER_BITS-1:0] s_tuser,      // mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata       // next_pc, out_valid, out_char, halted
);

    localparam int DP_BITS  = $clog2(TAPE_DEPTH);
    localparam int CMP_BITS = (PC_BITS > LEN_BITS) ? PC_BITS : LEN_BITS;
    localparam logic [DP_BITS-1:0] DP_LAST = DP_BITS'(TAPE_DEPTH - 1);

    logic [LEN_BITS-1:0]    prog_len_reg;
    logic [PC_BITS-1:0]     pc_reg;
    logic [DP_BITS-1:0]     dp_reg;
    logic                   halt_reg;
    logic [CELL_BITS-1:0]   cell_reg;
    logic [CELL_BITS-1:0]   cell_next;
    logic                   from_ram_reg;
    logic                   from_ram_next;
    logic                   clr_active_reg;
    logic [DP_BITS-1:0]     clr_addr_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_BITS-1:0] m_tdata_reg;

    logic                 accept;
    logic                 halt_entry;
    logic                 exec_go;
    logic [CELL_BITS-1:0] cur_cell;
    logic [CELL_BITS-1:0] ram_rdata;
    exec_ctrl_t           ctrl;
    logic [CELL_BITS-1:0] cell_exec;
    logic [DP_BITS-1:0]   dp_exec;
    logic [PC_BITS-1:0]   pc_exec;
    logic                 halt_exec;

    logic                 ram_we;
    logic [DP_BITS-1:0]   ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;
    logic                 ram_re;

    logic [NPC_BITS-1:0]  res_pc;
    logic                 res_ov;
    logic [CHAR_BITS-1:0] res_char;
    logic                 res_halt;

    assign s_tready   = !clr_active_reg && (!m_tvalid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign cur_cell   = from_ram_reg ? ram_rdata : cell_reg;
    assign halt_entry = halt_reg || (CMP_BITS'(pc_reg) >= CMP_BITS'(prog_len_reg));
    assign exec_go    = accept && !halt_entry;
    assign halt_exec  = CMP_BITS'(pc_exec) >= CMP_BITS'(prog_len_reg);

    bbc_exec #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .CELL_BITS  (CELL_BITS),
        .PC_BITS    (PC_BITS)
    ) u_exec (
        .op        (op_t'(s_tuser)),
        .jdist     (s_tdata[7:0]),
        .cbyte     (s_tdata[15:8]),
        .ceof      (s_tdata[16]),
        .cell_in   (cur_cell),
        .dp        (dp_reg),
        .pc        (pc_reg),
        .ctrl      (ctrl),
        .cell_next (cell_exec),
        .dp_next   (dp_exec),
        .pc_next   (pc_exec)
    );

    assign ram_we    = clr_active_reg || (exec_go && ctrl.cell_we);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : dp_reg;
    assign ram_wdata = clr_active_reg ? '0 : cell_exec;
    assign ram_re    = exec_go && ctrl.ptr_move;

    bbc_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dp_exec),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cell_next     = cur_cell;
        from_ram_next = 1'b0;
        if (exec_go && ctrl.cell_we)
        begin
            cell_next = cell_exec;
        end
        if (exec_go && ctrl.ptr_move)
        begin
            from_ram_next = 1'b1;
        end
    end

    always_comb
    begin
        if (halt_entry)
        begin
            res_pc   = NPC_BITS'(pc_reg);
            res_ov   = 1'b0;
            res_char = '0;
            res_halt = 1'b1;
        end
        else
        begin
            res_pc   = NPC_BITS'(pc_exec);
            res_ov   = ctrl.out_valid;
            res_char = ctrl.out_valid ? cur_cell[CHAR_BITS-1:0] : '0;
            res_halt = halt_exec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg   <= '0;
            pc_reg         <= '0;
            dp_reg         <= '0;
            halt_reg       <= 1'b0;
            cell_reg       <= '0;
            from_ram_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                prog_len_reg <= cfg_wdata;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == DP_LAST)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            cell_reg     <= cell_next;
            from_ram_reg <= from_ram_next;
            if (accept)
            begin
                halt_reg <= halt_entry || halt_exec;
            end
            if (exec_go)
            begin
                pc_reg <= pc_exec;
                dp_reg <= dp_exec;
            end
            if (accept)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= M_DATA_BITS'({res_halt, res_char, res_ov, res_pc});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("instruction taken during tape clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && exec_go && ctrl.cell_we))
        else $error("tape read and write from one instruction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halt_entry) |=> (m_tvalid && m_tdata[25] && !m_tdata[16]))
        else $error("halted instruction not reported as halted");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[24:17] == '0))
        else $error("character without output flag");

endmodule
